// ----- design/pac_pkg.sv -----
// shared types, constants and saturation helper for the pid anti-windup controller
package pac_pkg;

  localparam int ValueWidth  = 32;
  localparam int FracBits    = 16;
  localparam int StepWidth   = ValueWidth - 1;
  localparam int AlphaWidth  = FracBits + 1;
  localparam int DivWidth    = ValueWidth + FracBits;
  localparam int CfgIdxWidth = 3;
  localparam int AlphaOne    = 1 << FracBits;
  localparam int AlphaMin    = ((1 << FracBits) + 500) / 1000;

  localparam int WindupModeDefault   = 0;
  localparam int BackCalcGainDefault = 6554;

  typedef logic signed [ValueWidth-1:0] val_t;
  typedef logic [StepWidth-1:0]         step_t;
  typedef logic [AlphaWidth-1:0]        alpha_t;

  localparam val_t ValMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam val_t ValMin = {1'b1, {(ValueWidth-1){1'b0}}};

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } pac_op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEG_GAIN    = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_FF_GAIN       = 3'd3,
    CFG_OUT_MIN       = 3'd4,
    CFG_OUT_MAX       = 3'd5,
    CFG_INTEG_LIMIT   = 3'd6,
    CFG_FILTER_WEIGHT = 3'd7
  } pac_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_FF,
    ST_DIFF,
    ST_DIV_WAIT,
    ST_MUL_F1,
    ST_MUL_F2,
    ST_DF_SUM,
    ST_MUL_D,
    ST_MUL_S1,
    ST_S1_WB,
    ST_MUL_S2,
    ST_STEP_WB,
    ST_SUM_A,
    ST_SUM_B,
    ST_SUM_C,
    ST_PROJ,
    ST_INTEG,
    ST_EXC,
    ST_BLEED_M,
    ST_BLEED_WB,
    ST_LIMIT,
    ST_RESP
  } pac_state_e;

  typedef struct packed {
    pac_op_e opcode;
    step_t   time_step;
    val_t    target;
    val_t    measured;
  } pac_in_t;

  typedef struct packed {
    val_t drive;
    val_t error_value;
    val_t integ_value;
    val_t deriv_value;
  } pac_out_t;

  function automatic val_t sat_mag(input logic neg, input logic [2*ValueWidth-1:0] m);
    logic [2*ValueWidth-1:0] lim;
    lim = {{(ValueWidth+1){1'b0}}, {(ValueWidth-1){1'b1}}};
    if (neg) begin
      if (m > lim + 1'b1) return ValMin;
      return val_t'({ValueWidth{1'b0}} - m[ValueWidth-1:0]);
    end
    if (m > lim) return ValMax;
    return val_t'(m[ValueWidth-1:0]);
  endfunction

endpackage

// ----- design/pid_antiwindup_controller.sv -----
// pid controller with derivative on measurement and anti-windup, sequenced on shared units
// sequence, input beat to result beat: an update runs the full loop, a first sample skips the divider
// back-calculation mode adds the excess and bleed steps; a clear item or zero time step goes to the result
// the 48-step divider runs on every later update; a stalled result holds the response state
// the input stalls until the last item reaches the output register; the next beat is taken while a result waits
// reset: asynchronous active low, loop state cleared, registers to their defaults
// a clear beat returns loop state to reset and keeps the registers
module pid_antiwindup_controller #(
  parameter int WINDUP_MODE = pac_pkg::WindupModeDefault,
  parameter int BLEED_GAIN  = pac_pkg::BackCalcGainDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pac_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [pac_pkg::ValueWidth-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pac_pkg::pac_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pac_pkg::pac_out_t                 out_data_o
);
  import pac_pkg::*;

  localparam alpha_t AlphaOneV = alpha_t'(AlphaOne);
  localparam alpha_t AlphaMinV = alpha_t'(AlphaMin);
  localparam val_t   BcGain    = val_t'(BLEED_GAIN);

  function automatic val_t lim_fn(input val_t v, input val_t lo, input val_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // registers
  val_t   kp_q, ki_q, kd_q, kff_q, omin_q, omax_q;
  step_t  ilim_q;
  alpha_t fw_q;

  // loop state
  val_t integ_q, last_q, df_q, hdrive_q, herr_q;
  logic first_q;

  // working values
  step_t dt_q;
  val_t  sp_q, ms_q, err_q, p_q, ff_q, raw_q, t_q, d_q, step_q, acc_q;
  logic  hold_q, pass_q;

  pac_state_e state_q, state_d;

  logic     out_valid_q;
  pac_out_t out_q;

  logic in_acc;
  logic out_free;

  val_t                  add_a, add_b, add_res;
  logic                  add_sub;
  logic [ValueWidth:0]   add_sum;
  val_t                  mul_a, mul_b, mul_res;
  logic                  div_start, div_done;
  val_t                  div_quo;
  val_t                  ilim_pos, ilim_neg, fw_ext, fw_cmp_ext, dt_ext, proj;
  alpha_t                cfg_alpha;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ilim_pos   = val_t'({1'b0, ilim_q});
  assign ilim_neg   = val_t'({ValueWidth{1'b0}} - {1'b0, ilim_q});
  assign fw_ext     = val_t'({{(ValueWidth-AlphaWidth){1'b0}}, fw_q});
  assign fw_cmp_ext = val_t'({{(ValueWidth-AlphaWidth){1'b0}}, AlphaOneV - fw_q});
  assign dt_ext     = val_t'({1'b0, dt_q});
  assign cfg_alpha  = cfg_data_i[AlphaWidth-1:0];

  // shared saturating adder
  assign add_sum = add_sub ? ({add_a[ValueWidth-1], add_a} - {add_b[ValueWidth-1], add_b})
                           : ({add_a[ValueWidth-1], add_a} + {add_b[ValueWidth-1], add_b});
  assign add_res = (add_sum[ValueWidth] != add_sum[ValueWidth-1])
                 ? (add_sum[ValueWidth] ? ValMin : ValMax)
                 : val_t'(add_sum[ValueWidth-1:0]);
  assign proj    = add_res;

  pac_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  pac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (add_res),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    add_a     = '0;
    add_b     = '0;
    add_sub   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_CLEAR || in_data_i.time_step == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        add_a   = sp_q;
        add_b   = ms_q;
        add_sub = 1'b1;
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_a   = kp_q;
        mul_b   = err_q;
        state_d = ST_MUL_FF;
      end
      ST_MUL_FF: begin
        mul_a   = kff_q;
        mul_b   = sp_q;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        add_a     = last_q;
        add_b     = ms_q;
        add_sub   = 1'b1;
        div_start = !first_q;
        state_d   = first_q ? ST_MUL_F1 : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_d = ST_MUL_F1;
      end
      ST_MUL_F1: begin
        mul_a   = fw_ext;
        mul_b   = raw_q;
        state_d = ST_MUL_F2;
      end
      ST_MUL_F2: begin
        mul_a   = fw_cmp_ext;
        mul_b   = df_q;
        state_d = ST_DF_SUM;
      end
      ST_DF_SUM: begin
        add_a   = t_q;
        add_b   = mul_res;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a   = kd_q;
        mul_b   = df_q;
        state_d = ST_MUL_S1;
      end
      ST_MUL_S1: begin
        mul_a   = ki_q;
        mul_b   = err_q;
        state_d = ST_S1_WB;
      end
      ST_S1_WB: begin
        state_d = ST_MUL_S2;
      end
      ST_MUL_S2: begin
        mul_a   = t_q;
        mul_b   = dt_ext;
        state_d = ST_STEP_WB;
      end
      ST_STEP_WB: begin
        state_d = (WINDUP_MODE == 1) ? ST_INTEG : ST_SUM_A;
      end
      ST_SUM_A: begin
        add_a   = p_q;
        add_b   = integ_q;
        state_d = ST_SUM_B;
      end
      ST_SUM_B: begin
        add_a   = acc_q;
        add_b   = d_q;
        state_d = ST_SUM_C;
      end
      ST_SUM_C: begin
        add_a = acc_q;
        add_b = ff_q;
        if (pass_q) begin
          state_d = ST_LIMIT;
        end else if (WINDUP_MODE == 1) begin
          state_d = ST_EXC;
        end else begin
          state_d = ST_PROJ;
        end
      end
      ST_PROJ: begin
        add_a   = acc_q;
        add_b   = step_q;
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        add_a   = integ_q;
        add_b   = step_q;
        state_d = ST_SUM_A;
      end
      ST_EXC: begin
        add_a   = acc_q;
        add_b   = lim_fn(acc_q, omin_q, omax_q);
        add_sub = 1'b1;
        state_d = ST_BLEED_M;
      end
      ST_BLEED_M: begin
        mul_a   = BcGain;
        mul_b   = t_q;
        state_d = ST_BLEED_WB;
      end
      ST_BLEED_WB: begin
        add_a   = integ_q;
        add_b   = mul_res;
        add_sub = 1'b1;
        state_d = ST_SUM_A;
      end
      ST_LIMIT: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      kff_q  <= '0;
      omin_q <= ValMin;
      omax_q <= ValMax;
      ilim_q <= '1;
      fw_q   <= AlphaOneV;
    end else if (cfg_we_i) begin
      unique case (pac_cfg_e'(cfg_idx_i))
        CFG_PROP_GAIN:   kp_q   <= val_t'(cfg_data_i);
        CFG_INTEG_GAIN:  ki_q   <= val_t'(cfg_data_i);
        CFG_DERIV_GAIN:  kd_q   <= val_t'(cfg_data_i);
        CFG_FF_GAIN:     kff_q  <= val_t'(cfg_data_i);
        CFG_OUT_MIN:     omin_q <= val_t'(cfg_data_i);
        CFG_OUT_MAX:     omax_q <= val_t'(cfg_data_i);
        CFG_INTEG_LIMIT: ilim_q <= cfg_data_i[StepWidth-1:0];
        CFG_FILTER_WEIGHT: begin
          if (cfg_alpha > AlphaOneV) begin
            fw_q <= AlphaOneV;
          end else if (cfg_alpha < AlphaMinV) begin
            fw_q <= AlphaMinV;
          end else begin
            fw_q <= cfg_alpha;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      last_q   <= '0;
      df_q     <= '0;
      hdrive_q <= '0;
      herr_q   <= '0;
      first_q  <= 1'b1;
      dt_q     <= '0;
      sp_q     <= '0;
      ms_q     <= '0;
      err_q    <= '0;
      p_q      <= '0;
      ff_q     <= '0;
      raw_q    <= '0;
      t_q      <= '0;
      d_q      <= '0;
      step_q   <= '0;
      acc_q    <= '0;
      hold_q   <= 1'b0;
      pass_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            dt_q <= in_data_i.time_step;
            sp_q <= in_data_i.target;
            ms_q <= in_data_i.measured;
            if (in_data_i.opcode == OP_CLEAR) begin
              integ_q  <= '0;
              last_q   <= '0;
              df_q     <= '0;
              hdrive_q <= '0;
              herr_q   <= '0;
              first_q  <= 1'b1;
            end
          end
        end
        ST_ERR: begin
          err_q  <= add_res;
          herr_q <= add_res;
          pass_q <= 1'b0;
        end
        ST_MUL_FF: p_q <= mul_res;
        ST_DIFF: begin
          ff_q    <= mul_res;
          first_q <= 1'b0;
          last_q  <= ms_q;
          if (first_q) raw_q <= '0;
        end
        ST_DIV_WAIT: begin
          if (div_done) raw_q <= div_quo;
        end
        ST_MUL_F2:  t_q    <= mul_res;
        ST_DF_SUM:  df_q   <= add_res;
        ST_MUL_S1:  d_q    <= mul_res;
        ST_S1_WB:   t_q    <= mul_res;
        ST_STEP_WB: step_q <= mul_res;
        ST_SUM_A:   acc_q  <= add_res;
        ST_SUM_B:   acc_q  <= add_res;
        ST_SUM_C:   acc_q  <= add_res;
        ST_PROJ: begin
          hold_q <= (proj > omax_q && !err_q[ValueWidth-1] && err_q != '0) ||
                    (proj < omin_q && err_q[ValueWidth-1]);
        end
        ST_INTEG: begin
          if (WINDUP_MODE == 1 || !hold_q) integ_q <= lim_fn(add_res, ilim_neg, ilim_pos);
          pass_q <= (WINDUP_MODE == 0);
        end
        ST_EXC: t_q <= add_res;
        ST_BLEED_WB: begin
          integ_q <= add_res;
          pass_q  <= 1'b1;
        end
        ST_LIMIT: hdrive_q <= lim_fn(acc_q, omin_q, omax_q);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q       <= 1'b1;
      out_q.drive       <= hdrive_q;
      out_q.error_value <= herr_q;
      out_q.integ_value <= integ_q;
      out_q.deriv_value <= df_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fw_q >= AlphaMinV && fw_q <= AlphaOneV)
    else $error("filter weight out of range");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_RESP)
    else $error("result beat not loaded from response state");

  a_first_raw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIFF && first_q) |=> raw_q == '0)
    else $error("first sample derivative not zero");

endmodule

// ----- design/pac_mul.sv -----
// shared fixed-point multiplier, product registered, truncating shift and saturation after
module pac_mul (
  input  logic         clk_i,
  input  pac_pkg::val_t a_i,
  input  pac_pkg::val_t b_i,
  output pac_pkg::val_t res_o
);
  import pac_pkg::*;

  localparam int ProdWidth = 2 * ValueWidth;

  logic [ValueWidth-1:0] mag_a;
  logic [ValueWidth-1:0] mag_b;
  logic [ProdWidth-1:0]  prod_d, prod_q;
  logic                  neg_d, neg_q;

  assign mag_a  = a_i[ValueWidth-1] ? ({ValueWidth{1'b0}} - a_i) : a_i;
  assign mag_b  = b_i[ValueWidth-1] ? ({ValueWidth{1'b0}} - b_i) : b_i;
  assign neg_d  = a_i[ValueWidth-1] ^ b_i[ValueWidth-1];
  assign prod_d = ProdWidth'(mag_a) * ProdWidth'(mag_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  assign res_o = sat_mag(neg_q, prod_q >> FracBits);

endmodule

// ----- design/pac_div.sv -----
// radix-2 restoring divider for the fixed-point derivative quotient, one bit per cycle
module pac_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pac_pkg::val_t num_i,
  input  pac_pkg::step_t den_i,
  output logic          done_o,
  output pac_pkg::val_t quo_o
);
  import pac_pkg::*;

  localparam int CntWidth = $clog2(DivWidth);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(DivWidth - 1);

  logic                  busy_q, done_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  neg_q;
  step_t                 den_q;
  logic [ValueWidth-1:0] rem_q;
  logic [DivWidth-1:0]   dvd_q;

  logic [ValueWidth-1:0] mag_num;
  logic [ValueWidth-1:0] den_ext;
  logic [ValueWidth-1:0] rem_sh;
  logic                  ge;

  assign mag_num = num_i[ValueWidth-1] ? ({ValueWidth{1'b0}} - num_i) : num_i;
  assign den_ext = {1'b0, den_q};
  assign rem_sh  = {rem_q[ValueWidth-2:0], dvd_q[DivWidth-1]};
  assign ge      = rem_sh >= den_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[ValueWidth-1];
      den_q <= den_i;
      rem_q <= '0;
      dvd_q <= {mag_num, {FracBits{1'b0}}};
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - den_ext) : rem_sh;
      dvd_q <= {dvd_q[DivWidth-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_mag(neg_q, {{(2*ValueWidth-DivWidth){1'b0}}, dvd_q});

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the pid anti-windup controller with a bit-exact loop predictor
module testbench;
  import pac_pkg::*;

  localparam int     WindupMode = WindupModeDefault;
  localparam int     BackCalc   = BackCalcGainDefault;
  localparam longint QMax       = 64'sd2147483647;
  localparam longint QMin       = -64'sd2147483648;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [ValueWidth-1:0]  cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  pac_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pac_out_t out_data_o;

  pid_antiwindup_controller #(
    .WINDUP_MODE(WindupMode),
    .BLEED_GAIN (BackCalc)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // controller registers as the predictor sees them
  longint kp = 0, ki = 0, kd = 0, kf = 0;
  longint lim_lo = QMin, lim_hi = QMax, ilim = QMax, alpha = AlphaOne;
  // loop state
  longint integ = 0, prev_ms = 0, deriv_lp = 0, held_drv = 0, held_err = 0;
  bit     first_pass = 1'b1;

  pac_in_t  ctrl_items[$];
  pac_out_t ctrl_results[$];
  pac_out_t want;
  int       errors = 0, beats_in = 0, beats_out = 0, clears = 0, holds = 0, reg_writes = 0;
  int       send_gap = 0, hold_cnt = 0;
  bit       quiet = 1'b0;
  val_t     plant_sp = '0, plant_ms = '0;

  function automatic longint clip(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint from_mag(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'd2147483648) return QMin;
      return -longint'(m[63:0]);
    end
    if (m > 128'd2147483647) return QMax;
    return longint'(m[63:0]);
  endfunction

  function automatic longint fxmul(longint a, longint b);
    logic [63:0] ua, ub;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return from_mag((a < 0) != (b < 0), ({64'b0, ua} * {64'b0, ub}) >> FracBits);
  endfunction

  function automatic longint fxdiv(longint n, longint d);
    logic [127:0] un;
    un = (n < 0) ? -n : n;
    return from_mag(n < 0, (un << FracBits) / 128'(d));
  endfunction

  function automatic longint add4(longint a, longint b, longint c, longint d);
    return clip(clip(clip(a + b) + c) + d);
  endfunction

  function automatic pac_out_t pid_update(pac_in_t it);
    longint   dt, sp, ms, err, p, ff, raw, d, stp, proj, pre, excess;
    bit       hold;
    pac_out_t r;
    dt   = longint'(it.time_step);
    sp   = longint'($signed(it.target));
    ms   = longint'($signed(it.measured));
    raw  = 0;
    hold = 1'b0;
    if (it.opcode == OP_CLEAR) begin
      integ      = 0;
      prev_ms    = 0;
      deriv_lp   = 0;
      held_drv   = 0;
      held_err   = 0;
      first_pass = 1'b1;
    end else if (dt != 0) begin
      err      = clip(sp - ms);
      p        = fxmul(kp, err);
      ff       = fxmul(kf, sp);
      held_err = err;
      if (!first_pass) raw = fxdiv(clip(prev_ms - ms), dt);
      first_pass = 1'b0;
      prev_ms    = ms;
      deriv_lp   = clip(fxmul(alpha, raw) + fxmul(AlphaOne - alpha, deriv_lp));
      d          = fxmul(kd, deriv_lp);
      stp        = fxmul(fxmul(ki, err), dt);
      if (WindupMode != 1) begin
        proj = clip(add4(p, integ, d, ff) + stp);
        hold = (proj > lim_hi && err > 0) || (proj < lim_lo && err < 0);
      end
      if (!hold) integ = bound(clip(integ + stp), -ilim, ilim);
      if (WindupMode == 1) begin
        pre    = add4(p, integ, d, ff);
        excess = clip(pre - bound(pre, lim_lo, lim_hi));
        integ  = clip(integ - fxmul(BackCalc, excess));
      end
      held_drv = bound(add4(p, integ, d, ff), lim_lo, lim_hi);
    end
    r.drive       = val_t'(held_drv);
    r.error_value = val_t'(held_err);
    r.integ_value = val_t'(integ);
    r.deriv_value = val_t'(deriv_lp);
    return r;
  endfunction

  function automatic void check_field(string name, val_t exp_v, val_t act_v);
    if (exp_v !== act_v) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  function automatic logic [31:0] qint(int w);
    return w <<< FracBits;
  endfunction

  function automatic logic [31:0] gain_word();
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      v = int'($urandom_range(0, 524288)) - 262144;
      return v;
    end
    if (r < 9) return $urandom();
    r = $urandom_range(0, 3);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7FFF_FFFF;
    if (r == 2) return 32'hFFFF_FFFF;
    return '0;
  endfunction

  // register write, only while the controller is idle
  task automatic write_reg(pac_cfg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    reg_writes++;
    case (idx)
      CFG_PROP_GAIN:   kp = longint'($signed(val));
      CFG_INTEG_GAIN:  ki = longint'($signed(val));
      CFG_DERIV_GAIN:  kd = longint'($signed(val));
      CFG_FF_GAIN:     kf = longint'($signed(val));
      CFG_OUT_MIN:     lim_lo = longint'($signed(val));
      CFG_OUT_MAX:     lim_hi = longint'($signed(val));
      CFG_INTEG_LIMIT: ilim = longint'(val[ValueWidth-2:0]);
      CFG_FILTER_WEIGHT: begin
        alpha = bound(longint'(val[AlphaWidth-1:0]), AlphaMin, AlphaOne);
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] f,
                           logic [31:0] lo, logic [31:0] hi, logic [31:0] il,
                           logic [31:0] a);
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_FF_GAIN, f);
    write_reg(CFG_OUT_MIN, lo);
    write_reg(CFG_OUT_MAX, hi);
    write_reg(CFG_INTEG_LIMIT, il);
    write_reg(CFG_FILTER_WEIGHT, a);
  endtask

  task automatic push_item(pac_op_e op, step_t dt, logic [31:0] sp, logic [31:0] ms);
    pac_in_t it;
    it.opcode    = op;
    it.time_step = dt;
    it.target    = sp;
    it.measured  = ms;
    @(negedge clk_i);
    ctrl_items.push_back(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (ctrl_items.size() != 0 || in_valid_i || ctrl_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (100) @(negedge clk_i);
  endtask

  task automatic random_setup();
    logic [31:0] lo, hi, il, a;
    int r, m;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      m  = $urandom_range(1, 400);
      lo = qint(-m);
      m  = $urandom_range(1, 400);
      hi = qint(m);
    end else if (r < 8) begin
      lo = $urandom();
      hi = $urandom();
    end else if (r == 8) begin
      lo = 32'h8000_0000;
      hi = 32'h7FFF_FFFF;
    end else begin
      lo = qint($urandom_range(10, 100));
      hi = qint(-int'($urandom_range(10, 100)));
    end
    r = $urandom_range(0, 9);
    if (r < 6) il = $urandom_range(0, 300 << FracBits);
    else if (r == 6) il = '0;
    else if (r == 7) il = 32'h7FFF_FFFF;
    else il = $urandom();
    r = $urandom_range(0, 9);
    if (r < 6) a = $urandom_range(0, 32'h1FFFF);
    else if (r == 6) a = AlphaMin;
    else if (r == 7) a = AlphaOne;
    else a = $urandom();
    write_all(gain_word(), gain_word(), gain_word(), gain_word(), lo, hi, il, a);
  endtask

  // plant-like trajectories with occasional setpoint jumps, clears, holds and noise
  task automatic queue_random(int n);
    pac_in_t it;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      it.opcode = (r < 3) ? OP_CLEAR : OP_UPDATE;
      if (r < 6) it.time_step = '0;
      else if (r < 90) it.time_step = step_t'($urandom_range(65, 6554));
      else it.time_step = step_t'($urandom());
      if ($urandom_range(0, 9) == 0) begin
        it.target   = $urandom();
        it.measured = $urandom();
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          plant_sp = val_t'(int'($urandom_range(0, 400 << FracBits)) - (200 << FracBits));
        end
        plant_ms = val_t'(longint'(plant_ms)
                          + (longint'(plant_sp) - longint'(plant_ms)) / 8
                          + longint'(int'($urandom_range(0, 8192))) - 4096);
        it.target   = plant_sp;
        it.measured = plant_ms;
      end
      @(negedge clk_i);
      ctrl_items.push_back(it);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (ctrl_items.size() != 0) begin
        in_data_i  <= ctrl_items.pop_front();
        in_valid_i <= 1'b1;
        send_gap = quiet ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted input beat, checks each accepted result beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        ctrl_results.push_back(pid_update(in_data_i));
        beats_in++;
        if (in_data_i.opcode == OP_CLEAR) clears++;
        else if (in_data_i.time_step == '0) holds++;
      end
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (ctrl_results.size() == 0) begin
          errors++;
          $error("result beat with no pending expectation");
        end else begin
          want = ctrl_results.pop_front();
          check_field("drive", want.drive, out_data_o.drive);
          check_field("error_value", want.error_value, out_data_o.error_value);
          check_field("integ_value", want.integ_value, out_data_o.integ_value);
          check_field("deriv_value", want.deriv_value, out_data_o.deriv_value);
        end
        hold_cnt = quiet ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && hold_cnt != 0) begin
        hold_cnt--;
      end
      out_stall_i <= (hold_cnt != 0);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // moderate loop with tight limits
    write_all(qint(1), 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
              qint(-100), qint(100), qint(50), 32'h0000_8000);
    push_item(OP_UPDATE, 31'h0001_0000, qint(10), qint(0));
    push_item(OP_UPDATE, 31'h0001_0000, qint(10), qint(2));
    push_item(OP_UPDATE, '0, qint(7), qint(3));
    push_item(OP_UPDATE, 31'h0000_8000, qint(10), qint(1));
    push_item(OP_UPDATE, 31'd1, qint(10), qint(5));
    push_item(OP_UPDATE, 31'h7FFF_FFFF, qint(0), qint(0));
    push_item(OP_UPDATE, 31'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_item(OP_UPDATE, 31'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    repeat (3) push_item(OP_UPDATE, 31'h0001_0000, qint(1000), qint(0));
    repeat (3) push_item(OP_UPDATE, 31'h0001_0000, qint(-1000), qint(0));
    push_item(OP_CLEAR, step_t'($urandom()), $urandom(), $urandom());
    push_item(OP_UPDATE, '0, qint(4), qint(1));
    push_item(OP_UPDATE, 31'h0001_0000, qint(3), qint(1));
    push_item(OP_UPDATE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    drain();

    // extreme gains, crossed limits, zero integrator limit, weight below range
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              qint(50), qint(-50), 32'h0, 32'h0);
    push_item(OP_UPDATE, 31'h0001_0000, qint(1), qint(0));
    push_item(OP_UPDATE, 31'h0001_0000, qint(-1), qint(0));
    push_item(OP_UPDATE, 31'h0001_0000, qint(0), qint(0));
    push_item(OP_UPDATE, 31'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // weight above range, widest limits
    write_all(qint(2), qint(1), qint(1), qint(0), 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h0001_FFFF);
    push_item(OP_UPDATE, 31'h0000_1000, qint(20), qint(-20));
    push_item(OP_UPDATE, 31'h0000_1000, qint(20), qint(-10));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3);
      random_setup();
      queue_random(125);
      drain();
    end

    $display("ran %0d control beats (%0d clears, %0d zero-step holds) over %0d register writes",
             beats_in, clears, holds, reg_writes);
    $display("compared %0d result beats, %0d field mismatches", beats_out, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pac_pkg.sv
design/pac_mul.sv
design/pac_div.sv
design/pid_antiwindup_controller.sv
tb/testbench.sv
